@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker modules of the quaternion core.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle while reset is high.
`define RMQ_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, idle while reset is high.
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define RMQ_ASSERT_NEXT_ALL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rmq_pkg.sv @@
// Shared types of the rotation matrix to quaternion core.
// No dependencies.
`default_nettype none
package rmq_pkg;
   typedef enum logic [1:0] {
      BR_TRACE,
      BR_M0,
      BR_M5,
      BR_M10
   } branch_type;

   localparam int unsigned BRANCH_BITS = 2;
endpackage
`default_nettype wire

@@ hw/rtl/rmq_sqrt_pipe.sv @@
// Pipelined restoring integer square root, one result bit per stage.
// Carries a valid bit and an opaque sideband word alongside; uses rmq_pkg.
`default_nettype none
module rmq_sqrt_pipe
   import rmq_pkg::*;
#(
   parameter int unsigned ROOT_W = 16,
   parameter int unsigned SIDE_W = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [2*ROOT_W-1:0]   in_rad,
   input  wire logic [SIDE_W-1:0]     in_side,
   output logic                       out_valid,
   output logic [ROOT_W-1:0]          out_root,
   output logic [SIDE_W-1:0]          out_side
);
   localparam int unsigned VW = 2 * ROOT_W;
   localparam int unsigned RMW = ROOT_W + 2;

   logic              valid_ff [ROOT_W];
   logic [VW-1:0]     rad_ff   [ROOT_W];
   logic [RMW-1:0]    rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff  [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic              valid_prev;
      logic [VW-1:0]     rad_prev;
      logic [RMW-1:0]    rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [RMW:0]      rem_shift;
      logic [RMW:0]      trial;
      logic [RMW-1:0]    rem_in;
      logic [ROOT_W-1:0] root_in;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rad_prev   = in_rad;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign rad_prev   = rad_ff[i-1];
         assign rem_prev   = rem_ff[i-1];
         assign root_prev  = root_ff[i-1];
         assign side_prev  = side_ff[i-1];
      end

      always_comb begin
         rem_shift = {rem_prev[RMW-2:0], rad_prev[VW-1:VW-2]};
         trial     = (RMW+1)'({root_prev, 2'b01});
         if (rem_shift >= trial) begin
            rem_in  = RMW'(rem_shift - trial);
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = RMW'(rem_shift);
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_prev;
         end
         if (en) begin
            rad_ff[i]  <= {rad_prev[VW-3:0], 2'b00};
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];
endmodule
`default_nettype wire

@@ hw/rtl/rmq_div_pipe.sv @@
// Pipelined restoring unsigned divider, one numerator bit per stage.
// Keeps the low QUOT_W quotient bits; carries valid and a sideband word.
`default_nettype none
module rmq_div_pipe
   import rmq_pkg::*;
#(
   parameter int unsigned NUM_W  = 28,
   parameter int unsigned DEN_W  = 16,
   parameter int unsigned QUOT_W = 14,
   parameter int unsigned SIDE_W = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [NUM_W-1:0]   in_num,
   input  wire logic [DEN_W-1:0]   in_den,
   input  wire logic [SIDE_W-1:0]  in_side,
   output logic                    out_valid,
   output logic [QUOT_W-1:0]       out_quot,
   output logic [SIDE_W-1:0]       out_side
);
   localparam int unsigned RMW = DEN_W + 1;

   logic              valid_ff [NUM_W];
   logic [NUM_W-1:0]  num_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff   [NUM_W];
   logic [RMW-1:0]    rem_ff   [NUM_W];
   logic [QUOT_W-1:0] quot_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic              valid_prev;
      logic [NUM_W-1:0]  num_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [RMW-1:0]    rem_prev;
      logic [QUOT_W-1:0] quot_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [RMW-1:0]    rem_shift;
      logic [RMW-1:0]    rem_in;
      logic              qbit;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign num_prev   = in_num;
         assign den_prev   = in_den;
         assign rem_prev   = '0;
         assign quot_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign num_prev   = num_ff[i-1];
         assign den_prev   = den_ff[i-1];
         assign rem_prev   = rem_ff[i-1];
         assign quot_prev  = quot_ff[i-1];
         assign side_prev  = side_ff[i-1];
      end

      always_comb begin
         rem_shift = {rem_prev[RMW-2:0], num_prev[NUM_W-1]};
         qbit      = (rem_shift >= RMW'(den_prev));
         rem_in    = qbit ? RMW'(rem_shift - RMW'(den_prev)) : rem_shift;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_prev;
         end
         if (en) begin
            num_ff[i]  <= num_prev << 1;
            den_ff[i]  <= den_prev;
            rem_ff[i]  <= rem_in;
            quot_ff[i] <= QUOT_W'({quot_prev, qbit});
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quot  = quot_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];
endmodule
`default_nettype wire

@@ hw/rtl/rotation_matrix_to_quaternion_core.sv @@
// Rotation matrix to unit quaternion, fixed point, fully pipelined.
// Uses rmq_pkg, rmq_sqrt_pipe and rmq_div_pipe.
//
// Usage:
//  - Request channel: req_valid with the nine matrix elements, req_stall back.
//    A request is taken on a clock edge with req_valid high and req_stall low.
//  - Response channel: rsp_valid with quat_x/y/z/w, rsp_stall from the sink.
//  - One request per cycle is accepted while the response side keeps up.
//  - Stages: one select stage, one square root stage per root bit, one
//    divider stage per numerator bit, a multiply stage and the saturating
//    output register. The default format is 16-bit Q2.14.
//  - The whole pipeline moves as one; the response register is its last
//    stage. While a response sits in it and rsp_stall is high the pipeline
//    holds and req_stall goes high in the same cycle.
//  - Synchronous reset drops every in-flight request and clears rsp_valid.
`default_nettype none
module rotation_matrix_to_quaternion_core
   import rmq_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = 16,
   parameter int unsigned FRAC_BITS  = 14
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [DATA_WIDTH-1:0] req_elem_0,
   input  wire logic signed [DATA_WIDTH-1:0] req_elem_1,
   input  wire logic signed [DATA_WIDTH-1:0] req_elem_2,
   input  wire logic signed [DATA_WIDTH-1:0] req_elem_4,
   input  wire logic signed [DATA_WIDTH-1:0] req_elem_5,
   input  wire logic signed [DATA_WIDTH-1:0] req_elem_6,
   input  wire logic signed [DATA_WIDTH-1:0] req_elem_8,
   input  wire logic signed [DATA_WIDTH-1:0] req_elem_9,
   input  wire logic signed [DATA_WIDTH-1:0] req_elem_10,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0]      rsp_quat_x,
   output logic signed [DATA_WIDTH-1:0]      rsp_quat_y,
   output logic signed [DATA_WIDTH-1:0]      rsp_quat_z,
   output logic signed [DATA_WIDTH-1:0]      rsp_quat_w
);
   localparam int unsigned DW     = DATA_WIDTH;
   localparam int unsigned F      = FRAC_BITS;
   localparam int unsigned RW     = ((F > DW) ? F : DW) + 2;
   localparam int unsigned EW     = RW + 1;
   localparam int unsigned VW     = RW + F;
   localparam int unsigned ROOT_W = (VW + 1) / 2;
   localparam int unsigned VWP    = 2 * ROOT_W;
   localparam int unsigned DX     = DW + 2;
   localparam int unsigned NUM_W  = (((2*F-1) > ROOT_W) ? (2*F-1) : ROOT_W) + 1;
   localparam int unsigned KW     = F;
   localparam int unsigned PW     = DX + KW + 2;
   localparam int unsigned SSIDE  = 4*DX + BRANCH_BITS;
   localparam int unsigned DSIDE  = SSIDE + ROOT_W;

   localparam logic signed [EW-1:0] ONE_E   = EW'(1) << F;
   localparam logic signed [PW-1:0] HALF_P  = PW'(1) << (F - 1);
   localparam logic signed [PW-1:0] SAT_MAX = (PW'(1) << (DW - 1)) - PW'(1);
   localparam logic signed [PW-1:0] SAT_MIN = -(PW'(1) << (DW - 1));

   logic en;

   // front select stage
   logic signed [EW-1:0] m0, m1, m2, m4, m5, m6, m8, m9, m10, trace, rad;
   logic signed [EW-1:0] s41, s28, s96, d96, d28, d41;
   branch_type           br;
   logic signed [DX-1:0] dx_in, dy_in, dz_in, dw_in;

   logic                 sel_valid_ff;
   logic [RW-1:0]        sel_rad_ff;
   logic [SSIDE-1:0]     sel_side_ff;

   always_comb begin
      m0    = EW'(req_elem_0);
      m1    = EW'(req_elem_1);
      m2    = EW'(req_elem_2);
      m4    = EW'(req_elem_4);
      m5    = EW'(req_elem_5);
      m6    = EW'(req_elem_6);
      m8    = EW'(req_elem_8);
      m9    = EW'(req_elem_9);
      m10   = EW'(req_elem_10);
      s41   = m4 + m1;
      s28   = m2 + m8;
      s96   = m9 + m6;
      d96   = m9 - m6;
      d28   = m2 - m8;
      d41   = m4 - m1;
      trace = m0 + m5 + m10;
      if (trace >= 0) begin
         br  = BR_TRACE;
         rad = ONE_E + trace;
      end else if (m0 > m5 && m0 > m10) begin
         br  = BR_M0;
         rad = ONE_E + m0 - m5 - m10;
      end else if (m5 > m10) begin
         br  = BR_M5;
         rad = ONE_E + m5 - m0 - m10;
      end else begin
         br  = BR_M10;
         rad = ONE_E + m10 - m0 - m5;
      end
      if (rad < ONE_E) begin
         rad = ONE_E;
      end
      case (br)
         BR_TRACE: begin
            dx_in = DX'(d96); dy_in = DX'(d28); dz_in = DX'(d41); dw_in = '0;
         end
         BR_M0: begin
            dx_in = '0; dy_in = DX'(s41); dz_in = DX'(s28); dw_in = DX'(d96);
         end
         BR_M5: begin
            dx_in = DX'(s41); dy_in = '0; dz_in = DX'(s96); dw_in = DX'(d28);
         end
         default: begin
            dx_in = DX'(s28); dy_in = DX'(s96); dz_in = '0; dw_in = DX'(d41);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else if (en) begin
         sel_valid_ff <= req_valid;
      end
      if (en) begin
         sel_rad_ff  <= rad[RW-1:0];
         sel_side_ff <= {dx_in, dy_in, dz_in, dw_in, br};
      end
   end

   // square root of the radicand in Q format
   logic                 sq_valid;
   logic [ROOT_W-1:0]    sq_root;
   logic [SSIDE-1:0]     sq_side;

   rmq_sqrt_pipe #(
      .ROOT_W (ROOT_W),
      .SIDE_W (SSIDE)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sel_valid_ff),
      .in_rad    (VWP'({sel_rad_ff, F'(0)})),
      .in_side   (sel_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // reciprocal 0.5 / S, rounded to nearest
   logic [NUM_W-1:0]  div_num;
   logic [ROOT_W-1:0] main_val;
   logic              dv_valid;
   logic [KW-1:0]     dv_k;
   logic [DSIDE-1:0]  dv_side;

   assign div_num  = (NUM_W'(1) << (2*F - 1)) + NUM_W'(sq_root >> 1);
   assign main_val = ROOT_W'((ROOT_W+1)'(sq_root) + (ROOT_W+1)'(1) >> 1);

   rmq_div_pipe #(
      .NUM_W  (NUM_W),
      .DEN_W  (ROOT_W),
      .QUOT_W (KW),
      .SIDE_W (DSIDE)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_num    (div_num),
      .in_den    (sq_root),
      .in_side   ({main_val, sq_side}),
      .out_valid (dv_valid),
      .out_quot  (dv_k),
      .out_side  (dv_side)
   );

   // multiply stage
   logic signed [DX-1:0] dv_d [4];
   logic signed [PW-1:0] k_ext;
   logic signed [PW-1:0] prod_ff [4];
   logic [ROOT_W-1:0]    mul_main_ff;
   branch_type           mul_br_ff;
   logic                 mul_valid_ff;

   assign dv_d[0] = dv_side[BRANCH_BITS + 4*DX - 1 -: DX];
   assign dv_d[1] = dv_side[BRANCH_BITS + 3*DX - 1 -: DX];
   assign dv_d[2] = dv_side[BRANCH_BITS + 2*DX - 1 -: DX];
   assign dv_d[3] = dv_side[BRANCH_BITS + DX - 1 -: DX];
   assign k_ext   = PW'(dv_k);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= dv_valid;
      end
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= PW'(dv_d[i]) * k_ext + HALF_P;
         end
         mul_main_ff <= dv_side[DSIDE-1 -: ROOT_W];
         mul_br_ff   <= branch_type'(dv_side[BRANCH_BITS-1:0]);
      end
   end

   // scale down, pick the main component, saturate
   logic signed [PW-1:0] comp [4];
   logic signed [DW-1:0] sat  [4];
   logic                 rsp_valid_ff;
   logic signed [DW-1:0] quat_ff [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         comp[i] = prod_ff[i] >>> F;
      end
      case (mul_br_ff)
         BR_TRACE: comp[3] = PW'(mul_main_ff);
         BR_M0:    comp[0] = PW'(mul_main_ff);
         BR_M5:    comp[1] = PW'(mul_main_ff);
         default:  comp[2] = PW'(mul_main_ff);
      endcase
      for (int i = 0; i < 4; i++) begin
         if (comp[i] > SAT_MAX) begin
            sat[i] = DW'(SAT_MAX);
         end else if (comp[i] < SAT_MIN) begin
            sat[i] = DW'(SAT_MIN);
         end else begin
            sat[i] = DW'(comp[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= mul_valid_ff;
      end
      if (en) begin
         quat_ff <= sat;
      end
   end

   assign en         = !(rsp_valid_ff && rsp_stall);
   assign req_stall  = !en;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_x = quat_ff[0];
   assign rsp_quat_y = quat_ff[1];
   assign rsp_quat_z = quat_ff[2];
   assign rsp_quat_w = quat_ff[3];
endmodule
`default_nettype wire

@@ hw/rtl/rmq_checker.sv @@
// Port-level checks for rotation_matrix_to_quaternion_core, bound to it below.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rmq_checker #(
   parameter int unsigned DATA_WIDTH = 16
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [DATA_WIDTH-1:0] rsp_quat_x,
   input wire logic [DATA_WIDTH-1:0] rsp_quat_w
);
   `RMQ_ASSERT_NEXT_ALL(a_reset_clears, reset, !rsp_valid, "response valid after reset")
   `RMQ_ASSERT_SAME(a_stall_cause, req_stall, rsp_valid && rsp_stall, "request stall without response stall")
   `RMQ_ASSERT_SAME(a_flow, !rsp_stall, !req_stall, "request stalled while response drains")
   `RMQ_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_quat_x) && $stable(rsp_quat_w), "stalled response changed")
endmodule

bind rotation_matrix_to_quaternion_core rmq_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_rmq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_quat_x (rsp_quat_x),
   .rsp_quat_w (rsp_quat_w)
);
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for rotation_matrix_to_quaternion_core: directed table, then random matrices,
// each response checked field by field against a gold quaternion or a bit-exact calculator.
// Depends on rmq_pkg and the core RTL.
module tb;
   import rmq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = 16;
   localparam int FB = 14;
   localparam longint ONE = 64'sd1 <<< FB;
   localparam int RANDOM_ITEMS = 900;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES = 200;

   typedef logic signed [DW-1:0] word_type;
   typedef word_type [8:0] mat_type;
   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
      word_type w;
   } quat_type;
   typedef struct {
      mat_type m;
      bit gold_valid;
      quat_type gold;
   } request_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   mat_type req_mat = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   word_type rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;

   request_type requests[$];
   quat_type expected_quats[$];
   int send_idx = 0;
   int accept_idx = 0;
   int send_idle_pct = 27;
   int recv_idle_pct = 69;
   int cycles = 0;
   int errors = 0;
   bit held = 0;
   int hold_left = 0;

   rotation_matrix_to_quaternion_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_elem_0(req_mat[0]), .req_elem_1(req_mat[1]), .req_elem_2(req_mat[2]),
      .req_elem_4(req_mat[3]), .req_elem_5(req_mat[4]), .req_elem_6(req_mat[5]),
      .req_elem_8(req_mat[6]), .req_elem_9(req_mat[7]), .req_elem_10(req_mat[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_quat_x(rsp_quat_x), .rsp_quat_y(rsp_quat_y),
      .rsp_quat_z(rsp_quat_z), .rsp_quat_w(rsp_quat_w)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   function automatic longint isqrt_floor(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic word_type sat_word(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return word_type'(v);
   endfunction

   function automatic longint scale_half_up(longint d, longint k);
      return (d * k + (ONE >>> 1)) >>> FB;
   endfunction

   function automatic quat_type calc_quaternion(mat_type mt);
      longint m0, m1, m2, m4, m5, m6, m8, m9, m10, t, r, s, k, mc, x, y, z, w;
      branch_type br;
      quat_type q;
      m0 = longint'(mt[0]); m1 = longint'(mt[1]); m2 = longint'(mt[2]);
      m4 = longint'(mt[3]); m5 = longint'(mt[4]); m6 = longint'(mt[5]);
      m8 = longint'(mt[6]); m9 = longint'(mt[7]); m10 = longint'(mt[8]);
      t = m0 + m5 + m10;
      if (t >= 0) begin
         br = BR_TRACE; r = ONE + t;
      end else if (m0 > m5 && m0 > m10) begin
         br = BR_M0; r = ONE + m0 - m5 - m10;
      end else if (m5 > m10) begin
         br = BR_M5; r = ONE + m5 - m0 - m10;
      end else begin
         br = BR_M10; r = ONE + m10 - m0 - m5;
      end
      if (r < ONE) r = ONE;
      s = isqrt_floor(r <<< FB);
      mc = (s + 1) >>> 1;
      k = ((64'sd1 <<< (2 * FB - 1)) + (s >>> 1)) / s;
      case (br)
         BR_TRACE: begin
            w = mc; x = scale_half_up(m9 - m6, k);
            y = scale_half_up(m2 - m8, k); z = scale_half_up(m4 - m1, k);
         end
         BR_M0: begin
            x = mc; y = scale_half_up(m4 + m1, k);
            z = scale_half_up(m2 + m8, k); w = scale_half_up(m9 - m6, k);
         end
         BR_M5: begin
            y = mc; x = scale_half_up(m4 + m1, k);
            z = scale_half_up(m9 + m6, k); w = scale_half_up(m2 - m8, k);
         end
         default: begin
            z = mc; x = scale_half_up(m2 + m8, k);
            y = scale_half_up(m9 + m6, k); w = scale_half_up(m4 - m1, k);
         end
      endcase
      q.x = sat_word(x); q.y = sat_word(y); q.z = sat_word(z); q.w = sat_word(w);
      return q;
   endfunction

   function automatic mat_type mk(int e0, int e1, int e2, int e4, int e5, int e6,
                                  int e8, int e9, int e10);
      mat_type mt;
      mt[0] = word_type'(e0); mt[1] = word_type'(e1); mt[2] = word_type'(e2);
      mt[3] = word_type'(e4); mt[4] = word_type'(e5); mt[5] = word_type'(e6);
      mt[6] = word_type'(e8); mt[7] = word_type'(e9); mt[8] = word_type'(e10);
      return mt;
   endfunction

   task automatic add_row(mat_type mt, bit has_gold, quat_type q);
      request_type rq;
      rq.m = mt; rq.gold_valid = has_gold; rq.gold = q;
      requests.push_back(rq);
   endtask

   function automatic int rand_diag();
      int v;
      v = $urandom_range(32767, 8192);
      return $urandom_range(1) ? v : -v;
   endfunction

   task automatic build_requests();
      mat_type mt;
      int kind, d0, d5, d10;
      // identity, zero matrix, extreme elements, one case per diagonal branch
      add_row(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1, '{0, 0, 0, 16384});
      add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 8192});
      add_row(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 0, '0);
      add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
              0, '0);
      add_row(mk(-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768), 0, '0);
      add_row(mk(-32768, 32767, -32768, -32768, -32768, 32767, 32767, -32768, -32768),
              0, '0);
      add_row(mk(32767, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
              0, '0);
      add_row(mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 0, '0);
      add_row(mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 0, '0);
      add_row(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 0, '0);
      // ties in the largest diagonal element
      add_row(mk(-16384, 100, 200, 300, -16384, 400, 500, 600, -16384), 0, '0);
      add_row(mk(-100, 1, 2, 3, -100, 4, 5, 6, -16384), 0, '0);
      add_row(mk(-16384, 7, 8, 9, -100, 10, 11, 12, -100), 0, '0);
      // trace just below and at zero, then positive and large negative traces
      add_row(mk(-1, 5, -5, 9, 0, -9, 3, -3, 0), 0, '0);
      add_row(mk(16384, 1000, -1000, 2000, -16384, -2000, 3000, -3000, 0), 0, '0);
      add_row(mk(0, 11585, 0, -11585, 0, 0, 0, 0, 16384), 0, '0);
      add_row(mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767), 0, '0);
      add_row(mk(-32768, 32767, 32767, 32767, 32767, 32767, 32767, 32767, -32768), 0, '0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         kind = $urandom_range(9);
         for (int j = 0; j < 9; j++) mt[j] = word_type'($urandom);
         if (kind >= 3) begin
            d0 = rand_diag(); d5 = rand_diag(); d10 = rand_diag();
            if (kind == 9) begin
               d5 = d0;
               if ($urandom_range(1)) d10 = d0;
            end
            for (int j = 0; j < 9; j++) mt[j] = word_type'($urandom_range(32768) - 16384);
            mt[0] = word_type'(d0); mt[4] = word_type'(d5); mt[8] = word_type'(d10);
         end
         add_row(mt, 0, '0);
      end
   endtask

   initial begin
      build_requests();
      repeat (2) @(posedge clock);
      reset <= 0;
   end

   // request driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (send_idx + 1 > requests.size() / 3) begin
               send_idle_pct = 69; recv_idle_pct = 27;
            end
            if (send_idx + 1 > 2 * requests.size() / 3) begin
               send_idle_pct = 0; recv_idle_pct = 0;
            end
            send_idx = send_idx + 1;
            if (send_idx < requests.size() && $urandom_range(99) >= send_idle_pct) begin
               req_mat <= requests[send_idx].m;
            end else begin
               req_valid <= 0;
            end
         end else if (!req_valid && send_idx < requests.size() &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1;
            req_mat <= requests[send_idx].m;
         end
      end
   end

   // response sink, with one long hold so the pipeline backs up
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1;
      end else if (!held && accept_idx >= 100) begin
         held = 1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // predict on request, check on response
   always @(posedge clock) begin
      quat_type exp_q, got_q;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (requests[accept_idx].gold_valid) begin
               expected_quats.push_back(requests[accept_idx].gold);
            end else begin
               expected_quats.push_back(calc_quaternion(req_mat));
            end
            accept_idx = accept_idx + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            got_q = '{rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w};
            if (expected_quats.size() == 0) begin
               $display("%0t: unexpected response x=%0d y=%0d z=%0d w=%0d", $time,
                        got_q.x, got_q.y, got_q.z, got_q.w);
               errors = errors + 1;
            end else begin
               exp_q = expected_quats.pop_front();
               if (got_q.x !== exp_q.x) begin
                  $display("%0t: quat_x expected %0d got %0d", $time, exp_q.x, got_q.x);
                  errors = errors + 1;
               end
               if (got_q.y !== exp_q.y) begin
                  $display("%0t: quat_y expected %0d got %0d", $time, exp_q.y, got_q.y);
                  errors = errors + 1;
               end
               if (got_q.z !== exp_q.z) begin
                  $display("%0t: quat_z expected %0d got %0d", $time, exp_q.z, got_q.z);
                  errors = errors + 1;
               end
               if (got_q.w !== exp_q.w) begin
                  $display("%0t: quat_w expected %0d got %0d", $time, exp_q.w, got_q.w);
                  errors = errors + 1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      wait (requests.size() > 0 && !reset);
      while (send_idx < requests.size() || expected_quats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_quats.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
